>>> design/utu_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by every module of the block.
`default_nettype none

package utu_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [20:0] SUPP_BASE    = 21'h10000;
	localparam logic [20:0] SUPP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO      = 21'h00D7FF;
	localparam logic [20:0] SURR_HI      = 21'h00E000;
	localparam logic [15:0] HIGH_SURR    = 16'hD800;
	localparam logic [15:0] LOW_SURR     = 16'hDC00;

	localparam logic [7:0]  LEAD2_MIN    = 8'hC0;
	localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
	localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
	localparam logic [7:0]  LEAD_END     = 8'hF8;
	localparam logic [7:0]  ASCII_END    = 8'h80;

	localparam logic [2:0]  SEQ_LEN4     = 3'd4;

	typedef enum logic {
		UNIT_SINGLE,
		UNIT_PAIR
	} unit_kind_t;

	// One decoded character waiting for the back end.
	// SINGLE: value[15:0] is the code unit. PAIR: value is code point minus 0x10000.
	typedef struct packed {
		unit_kind_t  kind;
		logic [19:0] value;
	} char_entry_t;

endpackage

`default_nettype wire

>>> design/utu_front.sv
// Front end: accepts UTF-8 bytes, tracks the open sequence, classifies results.
// Depends on utu_pkg.
`default_nettype none

module utu_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  wire [7:0]           in_byte,
	output logic                push,
	output utu_pkg::char_entry_t entry
);
	import utu_pkg::*;

	logic [1:0]  pending_q;
	logic [20:0] acc_q;
	logic [2:0]  len_q;

	logic [1:0]  pending_nx;
	logic [20:0] acc_nx;
	logic [2:0]  len_nx;
	logic [20:0] acc_shift;
	logic [20:0] cp_off;

	assign acc_shift = {acc_q[14:0], in_byte[5:0]};
	assign cp_off    = acc_shift - SUPP_BASE;

	always_comb begin
		pending_nx = pending_q;
		acc_nx     = acc_q;
		len_nx     = len_q;
		push       = 1'b0;
		entry      = '{kind: UNIT_SINGLE, value: '0};
		if (in_byte == 8'h00) begin
			// terminator: drop any partial sequence
			pending_nx = '0;
			acc_nx     = '0;
			len_nx     = '0;
		end else if (pending_q != 2'd0) begin
			pending_nx = pending_q - 2'd1;
			acc_nx     = acc_shift;
			if (pending_nx == 2'd0) begin
				acc_nx = '0;
				len_nx = '0;
				if (len_q == SEQ_LEN4) begin
					if (!(acc_shift < SUPP_BASE || acc_shift > SUPP_MAX)) begin
						push  = 1'b1;
						entry = '{kind: UNIT_PAIR, value: cp_off[19:0]};
					end
				end else if (!(acc_shift > SURR_LO && acc_shift < SURR_HI)) begin
					push  = 1'b1;
					entry = '{kind: UNIT_SINGLE, value: {4'd0, acc_shift[15:0]}};
				end
			end
		end else begin
			priority if (in_byte < ASCII_END) begin
				push  = 1'b1;
				entry = '{kind: UNIT_SINGLE, value: {12'd0, in_byte}};
			end else if (in_byte < LEAD2_MIN) begin
				// stray continuation: ignore
			end else if (in_byte < LEAD3_MIN) begin
				acc_nx     = {16'd0, in_byte[4:0]};
				pending_nx = 2'd1;
				len_nx     = 3'd2;
			end else if (in_byte < LEAD4_MIN) begin
				acc_nx     = {17'd0, in_byte[3:0]};
				pending_nx = 2'd2;
				len_nx     = 3'd3;
			end else if (in_byte < LEAD_END) begin
				acc_nx     = {18'd0, in_byte[2:0]};
				pending_nx = 2'd3;
				len_nx     = SEQ_LEN4;
			end else begin
				// invalid lead: ignore
			end
		end
		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			acc_q     <= '0;
			len_q     <= '0;
		end else if (accept) begin
			pending_q <= pending_nx;
			acc_q     <= acc_nx;
			len_q     <= len_nx;
		end
	end

endmodule

`default_nettype wire

>>> design/utu_queue.sv
// Short FIFO of decoded characters between front and back end.
// Depends on utu_pkg.
`default_nettype none

module utu_queue #(
	parameter int unsigned DEPTH = utu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  utu_pkg::char_entry_t wr_entry,
	input  wire                  pop,
	output utu_pkg::char_entry_t rd_entry,
	output logic                 not_empty,
	output logic                 full
);
	import utu_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	char_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

>>> design/utu_back.sv
// Back end: turns queued characters into UTF-16 code units on the output register.
// Depends on utu_pkg.
`default_nettype none

module utu_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  utu_pkg::char_entry_t rd_entry,
	input  wire                  not_empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [15:0]          out_unit,
	output logic                 out_last
);
	import utu_pkg::*;

	logic        valid_q;
	logic [15:0] unit_q;
	logic        last_q;
	logic        low_pend_q;
	logic [9:0]  low_bits_q;
	logic        load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !low_pend_q && not_empty;
	assign out_valid = valid_q;
	assign out_unit  = unit_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (low_pend_q) begin
				unit_q <= LOW_SURR + {6'd0, low_bits_q};
				last_q <= 1'b1;
			end else if (not_empty) begin
				unique case (rd_entry.kind)
					UNIT_SINGLE: begin
						unit_q <= rd_entry.value[15:0];
						last_q <= 1'b1;
					end
					UNIT_PAIR: begin
						unit_q <= HIGH_SURR + {6'd0, rd_entry.value[19:10]};
						last_q <= 1'b0;
					end
					default: begin
						unit_q <= rd_entry.value[15:0];
						last_q <= 1'b1;
					end
				endcase
			end
			if (!low_pend_q) begin
				low_bits_q <= rd_entry.value[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			low_pend_q <= 1'b0;
		end else if (load) begin
			if (low_pend_q) begin
				valid_q    <= 1'b1;
				low_pend_q <= 1'b0;
			end else begin
				valid_q    <= not_empty;
				low_pend_q <= not_empty && (rd_entry.kind == UNIT_PAIR);
			end
		end
	end

	a_low_follows_high: assert property (@(posedge clk) disable iff (!arst_n)
		low_pend_q |-> valid_q && !last_q)
		else $error("low surrogate pending without high surrogate shown");

	a_high_has_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> low_pend_q)
		else $error("high surrogate shown with no low surrogate pending");

	a_low_after_high: assert property (@(posedge clk) disable iff (!arst_n)
		low_pend_q && out_ready |=> valid_q && last_q && unit_q[15:10] == LOW_SURR[15:10])
		else $error("low surrogate did not follow high surrogate");

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 transcoder: front end, character queue, back end.
// Depends on utu_pkg, utu_front, utu_queue and utu_back.
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   8      s_tdata[7:0] = in_byte (0x00 ends the string)
// m_axis    out  16+1   m_tdata[15:0] = code_unit, m_tlast = last_of_run
//
// The front end takes one byte per cycle while the queue has room; a byte's
// result is written to the queue and from there reaches the output register.
// The back end shows one code unit per cycle while m_tready is high; a
// four-byte sequence yields two units, so it holds the back end for both
// while the front end keeps taking bytes until the QUEUE_DEPTH-entry queue fills.
// Reset clears the open sequence, the queue and the output register; there is
// no clearing pass. A stall on m_tready backs up through the queue to s_tready.
module utf8_to_utf16_transcoder_unit #(
	parameter int unsigned QUEUE_DEPTH = utu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tlast    // last_of_run
);
	import utu_pkg::*;

	logic        accept;
	logic        push;
	logic        pop;
	logic        not_empty;
	logic        full;
	char_entry_t wr_entry;
	char_entry_t rd_entry;

	// take a byte whenever the queue can absorb its result
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	utu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_tdata),
		.push    (push),
		.entry   (wr_entry)
	);

	utu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.not_empty (not_empty),
		.full      (full)
	);

	utu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_entry  (rd_entry),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_unit  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

>>> tb/utu_tb_pkg.sv
// Prediction and checking for the UTF-8 to UTF-16 transcoder testbench.
// Depends on utu_pkg for the code point limits and lead byte bounds.
package utu_tb_pkg;

	import utu_pkg::*;

	typedef struct {
		logic [15:0] unit;
		logic        last;
	} utf16_word_t;

	class utf16_unit_checker;

		localparam logic [2:0] SEQ_IDLE = 3'd0;
		localparam logic [2:0] SEQ_LEN2 = 3'd2;
		localparam logic [2:0] SEQ_LEN3 = 3'd3;

		// decoder state, mirrors the block
		logic [1:0]  tails_left;
		logic [20:0] code_acc;
		logic [2:0]  seq_len;

		utf16_word_t units_due[$];
		int          n_taken;
		int          errors;

		function new();
			tails_left = '0;
			code_acc   = '0;
			seq_len    = SEQ_IDLE;
			n_taken    = 0;
			errors     = 0;
		endfunction

		function void drop_sequence();
			tails_left = '0;
			code_acc   = '0;
			seq_len    = SEQ_IDLE;
		endfunction

		function void due(input logic [15:0] unit, input logic last);
			utf16_word_t w;
			w.unit = unit;
			w.last = last;
			units_due.push_back(w);
		endfunction

		// Decode one accepted byte and queue the code units it yields.
		function void note_byte(input logic [7:0] b);
			logic [20:0] cp;
			logic [19:0] offs;
			logic [2:0]  len;
			if (b == 8'h00) begin
				drop_sequence();
				n_taken++;
				return;
			end
			if (tails_left != 0) begin
				n_taken++;
				code_acc   = {code_acc[14:0], b[5:0]};
				tails_left = tails_left - 2'd1;
				if (tails_left != 0)
					return;
				cp  = code_acc;
				len = seq_len;
				drop_sequence();
				if (len == SEQ_LEN4) begin
					if (cp < SUPP_BASE || cp > SUPP_MAX)
						return;
					offs = 20'(cp - SUPP_BASE);
					due(HIGH_SURR + 16'(offs[19:10]), 1'b0);
					due(LOW_SURR + 16'(offs[9:0]), 1'b1);
					return;
				end
				if (cp > SURR_LO && cp < SURR_HI)
					return;
				due(cp[15:0], 1'b1);
				return;
			end
			if (b < ASCII_END) begin
				n_taken++;
				due({8'h00, b}, 1'b1);
			end else if (b >= LEAD2_MIN && b < LEAD3_MIN) begin
				n_taken++;
				code_acc   = 21'(b[4:0]);
				tails_left = 2'd1;
				seq_len    = SEQ_LEN2;
			end else if (b >= LEAD3_MIN && b < LEAD4_MIN) begin
				n_taken++;
				code_acc   = 21'(b[3:0]);
				tails_left = 2'd2;
				seq_len    = SEQ_LEN3;
			end else if (b >= LEAD4_MIN && b < LEAD_END) begin
				n_taken++;
				code_acc   = 21'(b[2:0]);
				tails_left = 2'd3;
				seq_len    = SEQ_LEN4;
			end
		endfunction

		function void check_unit(input logic [15:0] unit, input logic last);
			utf16_word_t w;
			if (units_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: code_unit %h last_of_run %b",
					$time, unit, last);
				return;
			end
			w = units_due.pop_front();
			if (unit !== w.unit) begin
				errors++;
				$display("%0t: code_unit mismatch: expected %h actual %h",
					$time, w.unit, unit);
			end
			if (last !== w.last) begin
				errors++;
				$display("%0t: last_of_run mismatch: expected %b actual %b",
					$time, w.last, last);
			end
		endfunction

	endclass

endpackage

>>> tb/tb_top.sv
// Self-checking testbench for utf8_to_utf16_transcoder_unit: directed and random
// byte streams in, UTF-16 words checked against a decoder model in utu_tb_pkg.
// Depends on utu_pkg, utu_tb_pkg and the transcoder RTL.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import utu_pkg::*;
	import utu_tb_pkg::*;

	localparam int RANDOM_WORDS  = 1300;  // bytes that reach the decoder
	localparam int QUIET_AFTER   = 1150;  // no idling past this count
	localparam int HOLD_AT       = 400;   // long receiver hold-off starts here
	localparam int HOLD_CYCLES   = 200;
	localparam int STALL_LIMIT   = 1000;  // cycles with no word moved on either side
	localparam int DRAIN_CYCLES  = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	utf16_unit_checker chk = new();

	always #5 clk = ~clk;

	utf8_to_utf16_transcoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Idling comes in alternating windows of 100 words so that long runs
	// without gaps occur too; the tail of the run is always gap-free.
	function automatic bit idling_on();
		return chk.n_taken < QUIET_AFTER && ((chk.n_taken / 100) % 2 == 0);
	endfunction

	// Drive one byte on the slave side and hold it until it is taken.
	// Valid stays high between back-to-back words; a gap lowers it first.
	task automatic push_byte(input logic [7:0] b);
		int gap = 0;
		if (idling_on() && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 12);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		chk.note_byte(b);
	endtask

	// Continuation byte carrying six payload bits. Now and then the top two
	// bits are garbage: the block takes any nonzero byte inside a sequence.
	function automatic logic [7:0] tail_byte(input logic [5:0] bits6);
		logic [7:0] b;
		b = {2'b10, bits6};
		if ($urandom_range(0, 9) == 0)
			b[7:6] = 2'($urandom_range(0, 3));
		if (b == 8'h00)
			b = ASCII_END;  // a zero here would end the string instead
		return b;
	endfunction

	// Build one random token: mostly well-formed characters, some noise,
	// terminators and truncated sequences.
	task automatic send_token();
		logic [7:0]  seq[$];
		logic [20:0] cp;
		int          pick;
		int          full_len;
		int          cut;
		pick = $urandom_range(0, 99);
		cp   = 21'($urandom());
		if (pick < 30) begin
			seq.push_back(8'($urandom_range(1, 127)));
		end else if (pick < 50) begin
			// includes overlong forms, which pass unchecked
			seq.push_back({3'b110, cp[10:6]});
			seq.push_back(tail_byte(cp[5:0]));
		end else if (pick < 70) begin
			if ($urandom_range(0, 3) == 0)
				cp[15:11] = 5'b11011;  // land in the surrogate range
			seq.push_back({4'b1110, cp[15:12]});
			seq.push_back(tail_byte(cp[11:6]));
			seq.push_back(tail_byte(cp[5:0]));
		end else if (pick < 85) begin
			// mostly valid supplementary points; the rest any 21-bit value, often overlong or too large
			if ($urandom_range(0, 4) != 0)
				cp = 21'($urandom_range(SUPP_BASE, SUPP_MAX));
			seq.push_back({5'b11110, cp[20:18]});
			seq.push_back(tail_byte(cp[17:12]));
			seq.push_back(tail_byte(cp[11:6]));
			seq.push_back(tail_byte(cp[5:0]));
		end else if (pick < 90) begin
			seq.push_back(8'h00);
		end else if (pick < 95) begin
			seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			// truncated sequence: with no terminator after it, the next token's bytes get absorbed into it
			full_len = $urandom_range(2, 4);
			cut      = $urandom_range(1, full_len - 1);
			case (full_len)
				2: seq.push_back({3'b110, cp[4:0]});
				3: seq.push_back({4'b1110, cp[3:0]});
				default: seq.push_back({5'b11110, cp[2:0]});
			endcase
			repeat (cut - 1) seq.push_back(tail_byte(6'($urandom())));
			if ($urandom_range(0, 1) == 0)
				seq.push_back(8'h00);
		end
		foreach (seq[i])
			push_byte(seq[i]);
	endtask

	// Master side: random stall bursts, one long hold-off to back the queue
	// up into s_tready, and a steady ready at the end of the run.
	initial begin
		int  stall_left;
		bit  hold_done;
		bit  rdy;
		stall_left = 0;
		hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && chk.n_taken >= HOLD_AT) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idling_on() && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_tready <= rdy;
		end
	end

	// Check every word that leaves the block.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_unit(m_tdata, m_tlast);
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		int idle_cycles;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d words still due",
				$time, STALL_LIMIT, chk.units_due.size());
			$display("utf8_to_utf16_transcoder_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] directed[$];
		directed = '{
			8'h00, 8'h7F,                 // terminator while idle, top ASCII
			8'h80, 8'hFF, 8'hF8,          // stray continuation and invalid leads
			8'hC3, 8'hA9,                 // two-byte character
			8'hE2, 8'h82, 8'hAC,          // three-byte character
			8'hED, 8'hA0, 8'h80,          // decodes to a surrogate: drop
			8'hF4, 8'h8F, 8'hBF, 8'hBF,   // highest code point: surrogate pair
			8'hF0, 8'h80, 8'h80, 8'h80,   // overlong four-byte: drop
			8'hC0, 8'h41,                 // ASCII byte taken as a tail, overlong
			8'hE2, 8'h00                  // terminator inside a sequence
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			push_byte(directed[i]);
		while (chk.n_taken < RANDOM_WORDS)
			send_token();
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain: the watchdog bounds this wait.
		while (chk.units_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (chk.errors == 0 && chk.units_due.size() == 0) begin
			$display("utf8_to_utf16_transcoder_unit regression: pass");
		end else begin
			$display("utf8_to_utf16_transcoder_unit regression: fail");
		end
		$finish;
	end

endmodule
